// ===== hw/rtl/fcgi_pkg.sv =====
// Shared constants and types for the FastCGI response deframer.
// No dependencies; imported by the deframer, the result checker and the testbench.
package fcgi_pkg;

  localparam int unsigned HeaderBytes = 8;
  localparam int unsigned HdrIdxW     = $clog2(HeaderBytes);

  // Header byte positions
  localparam logic [HdrIdxW-1:0] HdrType   = HdrIdxW'(1);
  localparam logic [HdrIdxW-1:0] HdrIdHi   = HdrIdxW'(2);
  localparam logic [HdrIdxW-1:0] HdrIdLo   = HdrIdxW'(3);
  localparam logic [HdrIdxW-1:0] HdrLenHi  = HdrIdxW'(4);
  localparam logic [HdrIdxW-1:0] HdrLenLo  = HdrIdxW'(5);
  localparam logic [HdrIdxW-1:0] HdrPadLen = HdrIdxW'(6);
  localparam logic [HdrIdxW-1:0] HdrLast   = HdrIdxW'(HeaderBytes - 1);

  // Record types
  localparam logic [7:0] TypeEndRequest = 8'd3;
  localparam logic [7:0] TypeStdout     = 8'd6;

  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;

  // Result kinds
  localparam logic KindBody = 1'b0;
  localparam logic KindEnd  = 1'b1;

  typedef enum logic [3:0] {
    PhHeader   = 4'b0001,
    PhContent  = 4'b0010,
    PhPadding  = 4'b0100,
    PhFinished = 4'b1000
  } phase_e;

endpackage

// ===== hw/rtl/fcgi_if.sv =====
// Stream interfaces for the deframer: byte input and result output.
// Depends on nothing beyond the package order (no imports needed).
interface fcgi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface fcgi_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  body_byte;
  logic [15:0] record_request_id;

  modport source (output valid, output kind, output body_byte,
                  output record_request_id, input ready);
  modport sink   (input valid, input kind, input body_byte,
                  input record_request_id, output ready);
endinterface

// ===== hw/rtl/fastcgi_response_deframer.sv =====
// FastCGI response deframer: header parse, content/padding count, body filter.
// Depends on fcgi_pkg and the fcgi_in_if / fcgi_out_if interfaces.
// A result is registered: it appears in the output register in the cycle after its request.
// Throughput: one byte per cycle; the only stall is a held result not taken.
// Reset (rst_ni low, async): header phase, all counters and fields cleared,
//   output register empty.
module fastcgi_response_deframer
  import fcgi_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  fcgi_in_if.sink    in_i,
  fcgi_out_if.source out_o
);

  // Record state
  phase_e             phase_q,     phase_d;
  logic [HdrIdxW-1:0] hdr_idx_q,   hdr_idx_d;
  logic [7:0]         rec_type_q,  rec_type_d;
  logic [15:0]        req_id_q,    req_id_d;
  logic [15:0]        content_q,   content_d;
  logic [7:0]         padding_q,   padding_d;
  logic [1:0]         sep_match_q, sep_match_d;
  logic               sep_seen_q,  sep_seen_d;

  // Output register
  logic        out_valid_q;
  logic        res_valid;
  logic        res_kind;
  logic [7:0]  res_byte;
  logic        out_kind_q;
  logic [7:0]  out_byte_q;
  logic [15:0] out_id_q;

  logic       accept;
  logic [7:0] b;
  logic [15:0] content_dec;
  logic [7:0]  padding_dec;
  logic [7:0]  sep_want;
  logic        rec_is_end;

  // Output register frees up as it is taken, so a new request may enter alongside.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.in_byte;

  assign content_dec = content_q - 16'd1;
  assign padding_dec = padding_q - 8'd1;
  assign sep_want    = sep_match_q[0] ? ChLf : ChCr;
  assign rec_is_end  = (rec_type_q == TypeEndRequest);

  always_comb begin
    phase_d     = phase_q;
    hdr_idx_d   = hdr_idx_q;
    rec_type_d  = rec_type_q;
    req_id_d    = req_id_q;
    content_d   = content_q;
    padding_d   = padding_q;
    sep_match_d = sep_match_q;
    sep_seen_d  = sep_seen_q;
    res_valid   = 1'b0;
    res_kind    = KindBody;
    res_byte    = 8'd0;

    case (phase_q)
      PhHeader: begin
        case (hdr_idx_q)
          HdrType:   rec_type_d = b;
          HdrIdHi:   req_id_d[15:8] = b;
          HdrIdLo:   req_id_d[7:0] = b;
          HdrLenHi:  content_d[15:8] = b;
          HdrLenLo:  content_d[7:0] = b;
          HdrPadLen: padding_d = b;
          default: ;
        endcase
        if (hdr_idx_q == HdrLast) begin
          // Lengths are complete by now; decide where the record goes next.
          hdr_idx_d   = '0;
          sep_match_d = 2'd0;
          sep_seen_d  = 1'b0;
          if (content_q != 16'd0) begin
            phase_d = PhContent;
          end else if (padding_q != 8'd0) begin
            phase_d = PhPadding;
          end else if (rec_is_end) begin
            // Empty end-request record ends the stream on its last header byte
            phase_d   = PhFinished;
            res_valid = 1'b1;
            res_kind  = KindEnd;
          end
        end else begin
          hdr_idx_d = hdr_idx_q + HdrIdxW'(1);
        end
      end

      PhContent: begin
        if (rec_type_q == TypeStdout) begin
          if (sep_seen_q) begin
            res_valid = 1'b1;
            res_byte  = b;
          end else if (b == sep_want) begin
            if (sep_match_q == 2'd3) begin
              sep_seen_d  = 1'b1;
              sep_match_d = 2'd0;
            end else begin
              sep_match_d = sep_match_q + 2'd1;
            end
          end else begin
            sep_match_d = (b == ChCr) ? 2'd1 : 2'd0;
          end
        end
        content_d = content_dec;
        if (content_dec == 16'd0) begin
          if (padding_q != 8'd0) begin
            phase_d = PhPadding;
          end else if (rec_is_end) begin
            phase_d   = PhFinished;
            res_valid = 1'b1;
            res_kind  = KindEnd;
            res_byte  = 8'd0;
          end else begin
            phase_d   = PhHeader;
            hdr_idx_d = '0;
          end
        end
      end

      PhPadding: begin
        padding_d = padding_dec;
        if (padding_dec == 8'd0) begin
          if (rec_is_end) begin
            phase_d   = PhFinished;
            res_valid = 1'b1;
            res_kind  = KindEnd;
          end else begin
            phase_d   = PhHeader;
            hdr_idx_d = '0;
          end
        end
      end

      default: ; // finished: every later byte is dropped
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHeader;
      hdr_idx_q   <= '0;
      rec_type_q  <= 8'd0;
      req_id_q    <= 16'd0;
      content_q   <= 16'd0;
      padding_q   <= 8'd0;
      sep_match_q <= 2'd0;
      sep_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q     <= phase_d;
        hdr_idx_q   <= hdr_idx_d;
        rec_type_q  <= rec_type_d;
        req_id_q    <= req_id_d;
        content_q   <= content_d;
        padding_q   <= padding_d;
        sep_match_q <= sep_match_d;
        sep_seen_q  <= sep_seen_d;
        out_valid_q <= res_valid;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: id is the one in force when the byte arrived (header byte 7 sees
  // the fully loaded id already).
  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_kind_q <= res_kind;
      out_byte_q <= res_byte;
      out_id_q   <= req_id_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.kind              = out_kind_q;
  assign out_o.body_byte         = out_byte_q;
  assign out_o.record_request_id = out_id_q;

endmodule

// ===== bench/fastcgi_response_deframer_check.sv =====
// Result checker for the FastCGI response deframer: watches both channels,
// predicts results from the accepted byte stream and compares them.
// Depends on fcgi_pkg for header positions, record types and phases.
module fastcgi_response_deframer_check
  import fcgi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        out_kind_i,
  input  logic [7:0]  out_body_byte_i,
  input  logic [15:0] out_resp_id_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic        kind;
    logic [7:0]  body_byte;
    logic [15:0] resp_id;
  } deframer_result_t;

  deframer_result_t expected_results[$];
  deframer_result_t got;
  deframer_result_t want;

  // Predicted deframer state
  phase_e             phase;
  logic [HdrIdxW-1:0] hdr_idx;
  logic [7:0]         rec_type;
  logic [15:0]        rec_id;
  logic [15:0]        content_left;
  logic [7:0]         pad_left;
  logic [1:0]         sep_match;
  logic               sep_seen;

  // Record fully consumed; returns 1 when it was the end request.
  function automatic bit finish_record();
    if (rec_type == TypeEndRequest) begin
      phase = PhFinished;
      return 1'b1;
    end
    phase   = PhHeader;
    hdr_idx = '0;
    return 1'b0;
  endfunction

  task automatic predict_byte(input logic [7:0] b);
    logic [7:0] next_ch;
    bit         emit_body;
    bit         ended;
    emit_body = 1'b0;
    ended     = 1'b0;
    case (phase)
      PhHeader: begin
        case (hdr_idx)
          HdrType:   rec_type           = b;
          HdrIdHi:   rec_id[15:8]       = b;
          HdrIdLo:   rec_id[7:0]        = b;
          HdrLenHi:  content_left[15:8] = b;
          HdrLenLo:  content_left[7:0]  = b;
          HdrPadLen: pad_left           = b;
          default: ;
        endcase
        if (hdr_idx == HdrLast) begin
          hdr_idx   = '0;
          sep_match = 2'd0;
          sep_seen  = 1'b0;
          if (content_left != 16'd0) phase = PhContent;
          else if (pad_left != 8'd0) phase = PhPadding;
          else ended = finish_record();
        end else begin
          hdr_idx = hdr_idx + 1'b1;
        end
      end
      PhContent: begin
        if (rec_type == TypeStdout) begin
          if (sep_seen) begin
            emit_body = 1'b1;
          end else begin
            // CR LF CR LF matcher: odd counts wait for LF, even for CR
            next_ch = sep_match[0] ? ChLf : ChCr;
            if (b == next_ch) begin
              if (sep_match == 2'd3) begin
                sep_seen  = 1'b1;
                sep_match = 2'd0;
              end else begin
                sep_match = sep_match + 2'd1;
              end
            end else begin
              sep_match = (b == ChCr) ? 2'd1 : 2'd0;
            end
          end
        end
        content_left = content_left - 16'd1;
        if (content_left == 16'd0) begin
          if (pad_left != 8'd0) phase = PhPadding;
          else ended = finish_record();
        end
      end
      PhPadding: begin
        pad_left = pad_left - 8'd1;
        if (pad_left == 8'd0) ended = finish_record();
      end
      default: ;
    endcase
    if (emit_body) expected_results.push_back(deframer_result_t'{KindBody, b, rec_id});
    if (ended) expected_results.push_back(deframer_result_t'{KindEnd, 8'h00, rec_id});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase        = PhHeader;
      hdr_idx      = '0;
      rec_type     = 8'h00;
      rec_id       = 16'h0000;
      content_left = 16'h0000;
      pad_left     = 8'h00;
      sep_match    = 2'd0;
      sep_seen     = 1'b0;
      expected_results.delete();
    end else begin
      // Compare first: a result never leaves in the cycle of its own request.
      if (out_valid_i && out_ready_i) begin
        got = deframer_result_t'{out_kind_i, out_body_byte_i, out_resp_id_i};
        if (expected_results.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= ReportLimit)
            $display("unexpected result: kind=%0d byte=%02h id=%04h",
                     got.kind, got.body_byte, got.resp_id);
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.body_byte !== want.body_byte ||
              got.resp_id !== want.resp_id) begin
            fail_count_o = fail_count_o + 1;
            if (fail_count_o <= ReportLimit)
              $display("wrong result: exp kind=%0d byte=%02h id=%04h got kind=%0d byte=%02h id=%04h",
                       want.kind, want.body_byte, want.resp_id,
                       got.kind, got.body_byte, got.resp_id);
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_byte(in_byte_i);
    end
    pending_o = expected_results.size();
  end

endmodule

// ===== bench/tb_fastcgi_response_deframer.sv =====
// Testbench top for the FastCGI response deframer: clock, reset, byte stream
// stimulus, result sink with back-pressure, watchdog and verdict.
// Depends on fcgi_pkg, fcgi_in_if / fcgi_out_if and the result checker.
module tb_fastcgi_response_deframer;
  import fcgi_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;  // cycles with no request moving
  localparam int unsigned HoldCycles    = 400;   // one long sink hold-off
  localparam int unsigned RandomBytes   = 700;
  localparam int unsigned TailWait      = 8;
  localparam logic [7:0]  TypeStderr    = 8'd7;
  localparam logic [15:0] HoldLen       = 16'd48;  // content of the hold-off record
  localparam logic [7:0]  HoldPad       = 8'd5;

  // Where a record's content carries CR LF pieces
  typedef enum logic [1:0] {
    SepNone,   // only random bytes (still biased toward CR and LF)
    SepWhole,  // full separator near the start
    SepHead,   // CR LF at the very start: completes a split separator
    SepTail    // CR LF at the very end: first half of a split separator
  } sep_place_e;

  // Directed opening: an empty record with all-ones type and id, then a
  // stdout record whose separator is followed by the two extreme bytes.
  localparam logic [7:0] DirectedBytes [23] = '{
    8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF,
    8'h01, 8'h06, 8'h00, 8'h00, 8'h00, 8'h06, 8'h01, 8'h00,
    8'h0D, 8'h0A, 8'h0D, 8'h0A, 8'hFF, 8'h00,
    8'h5A
  };

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned idle_cycles;
  bit          eager;        // no idling on either side while set
  bit          hold_wanted;  // asks the sink for its long hold-off

  fcgi_in_if  in_ch ();
  fcgi_out_if out_ch ();

  fastcgi_response_deframer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  fastcgi_response_deframer_check u_result_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_ch.valid),
    .in_ready_i       (in_ch.ready),
    .in_byte_i        (in_ch.in_byte),
    .out_valid_i      (out_ch.valid),
    .out_ready_i      (out_ch.ready),
    .out_kind_i       (out_ch.kind),
    .out_body_byte_i  (out_ch.body_byte),
    .out_resp_id_i    (out_ch.record_request_id),
    .fail_count_o     (fail_count),
    .pending_o        (pending_count)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Offer one byte after a random gap; returns at the falling edge after the
  // request was taken. valid stays high when the next gap is zero.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = eager ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // One whole record: 8-byte header, content, padding.
  task automatic send_record(input logic [7:0] rtype, input logic [15:0] rid,
                             input logic [15:0] clen, input logic [7:0] plen,
                             input sep_place_e place);
    int unsigned sp;
    logic [7:0]  b;
    // keep the separator near the front so long records still emit a body
    sp = (clen > 16'd4) ? $urandom_range(0, (clen - 4 < 16) ? clen - 4 : 16) : 0;
    send_byte(8'($urandom));  // version, ignored
    send_byte(rtype);
    send_byte(rid[15:8]);
    send_byte(rid[7:0]);
    send_byte(clen[15:8]);
    send_byte(clen[7:0]);
    send_byte(plen);
    send_byte(8'($urandom));  // reserved, ignored
    for (int unsigned i = 0; i < clen; i++) begin
      // CR/LF-heavy noise makes partial and restarted matches common
      case ($urandom_range(0, 4))
        0:       b = ChCr;
        1:       b = ChLf;
        default: b = 8'($urandom);
      endcase
      case (place)
        SepWhole: if (clen >= 16'd4 && i >= sp && i < sp + 4) b = ((i - sp) % 2) ? ChLf : ChCr;
        SepHead:  if (i < 2) b = (i == 0) ? ChCr : ChLf;
        SepTail:  if (i + 2 >= clen) b = (i + 1 == clen) ? ChLf : ChCr;
        default: ;
      endcase
      send_byte(b);
    end
    repeat (plen) send_byte(8'($urandom));
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned sent;
    bit          big_sent;
    logic [7:0]  rtype;
    logic [15:0] clen;
    logic [7:0]  plen;
    sep_place_e  place;
    sent          = 0;
    big_sent      = 1'b0;
    eager         = 1'b0;
    hold_wanted   = 1'b0;
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DirectedBytes[i]) send_byte(DirectedBytes[i]);

    // Mostly well-formed records with random content; other types and odd
    // separator placement mixed in. End request is held back to the end,
    // since it shuts the block down until reset.
    while (sent < RandomBytes) begin
      if (!big_sent && sent >= RandomBytes / 2) begin
        // stdout record with a long body; the sink holds off meanwhile so the
        // output fills and the input stalls
        hold_wanted = 1'b1;
        send_record(TypeStdout, 16'($urandom), HoldLen, HoldPad, SepWhole);
        big_sent = 1'b1;
        sent += 8 + HoldLen + HoldPad;
      end
      eager = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: rtype = TypeStdout;
        6:                rtype = TypeStderr;
        7:                rtype = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: begin
          rtype = 8'($urandom);
          if (rtype == TypeEndRequest) rtype = TypeStderr;
        end
      endcase
      clen  = ($urandom_range(0, 29) == 0) ? 16'($urandom_range(256, 300))
                                           : 16'($urandom_range(0, 24));
      plen  = 8'($urandom_range(0, 7));
      place = sep_place_e'($urandom_range(0, 3));
      send_record(rtype, 16'($urandom), clen, plen, place);
      sent += 8 + clen + plen;
    end
    eager = 1'b0;

    // End request (sometimes empty), then a stdout record that must be ignored
    send_record(TypeEndRequest, 16'($urandom),
                $urandom_range(0, 1) ? 16'($urandom_range(1, 6)) : 16'h0000,
                $urandom_range(0, 1) ? 8'($urandom_range(1, 3)) : 8'h00, SepNone);
    send_record(TypeStdout, 16'($urandom), 16'd10, 8'd2, SepWhole);
    in_ch.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    repeat (TailWait) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("fastcgi_response_deframer: match");
    end else begin
      $display("fastcgi_response_deframer: mismatch");
    end
    $finish;
  end

  // Result sink: random hold-off per result, one long hold when asked
  initial begin
    int unsigned gap;
    out_ch.ready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      gap = eager ? 0 : $urandom_range(0, 3);
      if (hold_wanted) begin
        gap         = HoldCycles;
        hold_wanted = 1'b0;
      end
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      @(negedge clk_i);
    end
  end

  // Watchdog: too long without any request moving on either channel
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WatchdogLimit) begin
      $display("fastcgi_response_deframer: mismatch");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
hw/rtl/fcgi_pkg.sv
hw/rtl/fcgi_if.sv
hw/rtl/fastcgi_response_deframer.sv
bench/fastcgi_response_deframer_check.sv
bench/tb_fastcgi_response_deframer.sv
